// ===== rtl/lrmb_pkg.sv =====
package lrmb_pkg;

    // Fixed widths of the register file and the Jacobi datapath
    localparam int unsigned DATA_W = 32;   // write data, core value
    localparam int unsigned LEN_W  = 31;   // base factor, map length
    localparam int unsigned MOD_W  = 32;   // odd modulus 2i+1
    localparam int unsigned PROD_W = 63;   // core magnitude times base factor

    // Register indexes of the write port
    localparam logic [1:0] REG_CORE_VALUE  = 2'd0;
    localparam logic [1:0] REG_BASE_FACTOR = 2'd1;
    localparam logic [1:0] REG_PARITY_MODE = 2'd2;
    localparam logic [1:0] REG_MAP_LENGTH  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN1,
        ST_RUN2
    } state_t;

    // Command from the sequencer to the shared Jacobi unit
    typedef struct packed {
        logic              load;
        logic [PROD_W-1:0] a;
        logic [MOD_W-1:0]  m;
        logic              flip;
    } jac_cmd_t;

    // Status from the Jacobi unit
    typedef struct packed {
        logic done;
        logic one;
    } jac_stat_t;

endpackage

// ===== rtl/lrmb_jacobi.sv =====
module lrmb_jacobi (
    input  logic               clk,
    input  logic               rst_n,
    input  lrmb_pkg::jac_cmd_t cmd,
    output lrmb_pkg::jac_stat_t stat
);
    import lrmb_pkg::*;

    logic              active_reg, active_next;
    logic [PROD_W-1:0] a_reg, a_next;
    logic [MOD_W-1:0]  m_reg, m_next;
    logic              s_reg, s_next;   // 1 means the symbol is negated

    logic [PROD_W:0]   diff;
    logic              borrow;
    logic              a_zero;

    assign diff   = {1'b0, a_reg} - {{(PROD_W + 1 - MOD_W){1'b0}}, m_reg};
    assign borrow = diff[PROD_W];
    assign a_zero = (a_reg == '0);

    // One binary Jacobi step per cycle: halve, swap, or subtract
    always_comb
    begin
        active_next = active_reg;
        a_next      = a_reg;
        m_next      = m_reg;
        s_next      = s_reg;
        if (cmd.load)
        begin
            active_next = 1'b1;
            a_next      = cmd.a;
            m_next      = cmd.m;
            s_next      = cmd.flip;
        end
        else if (active_reg)
        begin
            priority if (a_zero)
            begin
                active_next = 1'b0;
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
                s_next = s_reg ^ ((m_reg[2:0] == 3'd3) || (m_reg[2:0] == 3'd5));
            end
            else if (borrow)
            begin
                // a < m: swap with quadratic reciprocity
                a_next = PROD_W'(m_reg);
                m_next = a_reg[MOD_W-1:0];
                s_next = s_reg ^ ((a_reg[1:0] == 2'd3) && (m_reg[1:0] == 2'd3));
            end
            else
            begin
                a_next = diff[PROD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        m_reg <= m_next;
        s_reg <= s_next;
    end

    assign stat.done = active_reg && a_zero;
    assign stat.one  = (m_reg == MOD_W'(1)) && !s_reg;

    // Odd moduli stay odd through every swap
    a_m_odd: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> m_reg[0])
        else $error("jacobi modulus became even");

    a_load_active: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> active_reg)
        else $error("jacobi unit did not start on load");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && a_zero && !cmd.load) |=> !active_reg)
        else $error("jacobi unit kept running after finishing");

endmodule

// ===== rtl/legendre_residue_map_bit.sv =====
// Residue map bit tester. Each transaction on start/map_index asks whether
// bit i of a quadratic-residue map is set: the block computes the Jacobi
// symbol of the signed core value r modulo 2i+1 and sets map_bit when it is
// 1; in mixed parity mode, when that symbol is not 1, it also tests r
// times base_factor. The result appears on map_bit/in_range for exactly
// one cycle with done high, and the receiver cannot stall it, so sample it
// in that cycle. An index at or beyond map_length answers in the cycle
// after an accepted start with in_range low and map_bit low. An in-range
// index occupies the block (busy high) while one shared step unit runs the
// binary Jacobi algorithm, one halve, swap or subtract per cycle. The shared
// subtract/compare step of that unit sets the rate. Write the registers only
// while busy is low and no result is pending.
module legendre_residue_map_bit #(
    parameter int unsigned INDEX_WIDTH = 31
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [1:0]                wr_index,
    input  logic [lrmb_pkg::DATA_W-1:0] wr_data,
    input  logic                      start,
    input  logic [INDEX_WIDTH-1:0]    map_index,
    output logic                      busy,
    output logic                      done,
    output logic                      map_bit,
    output logic                      in_range
);
    import lrmb_pkg::*;

    // Configuration registers
    logic [DATA_W-1:0] core_value_reg;
    logic [LEN_W-1:0]  base_factor_reg;
    logic              parity_mode_reg;
    logic [LEN_W-1:0]  map_length_reg;

    // Sequencer and per-transaction operands
    state_t            state_reg, state_next;
    logic              done_reg, done_next;
    logic              map_bit_reg, map_bit_next;
    logic              in_range_reg, in_range_next;
    logic [MOD_W-1:0]  n_reg;
    logic [DATA_W-1:0] mag_reg;
    logic              flip_reg;

    logic              accept;
    logic              idx_low;
    logic              neg;
    logic [DATA_W-1:0] mag_comb;
    logic [MOD_W-1:0]  n_comb;
    logic              flip_comb;
    logic [PROD_W-1:0] prod_full;

    jac_cmd_t          cmd;
    jac_stat_t         stat;

    // Register writes; the index space is exactly the four registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_value_reg  <= DATA_W'(1);
            base_factor_reg <= LEN_W'(1);
            parity_mode_reg <= 1'b0;
            map_length_reg  <= LEN_W'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CORE_VALUE:  core_value_reg  <= wr_data;
                REG_BASE_FACTOR: base_factor_reg <= wr_data[LEN_W-1:0];
                REG_PARITY_MODE: parity_mode_reg <= wr_data[0];
                REG_MAP_LENGTH:  map_length_reg  <= wr_data[LEN_W-1:0];
                default:         core_value_reg  <= core_value_reg;
            endcase
        end
    end

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign idx_low = (32'(map_index) < 32'(map_length_reg));

    // Split r into magnitude and sign; -r flips the symbol when n = 3 mod 4
    assign neg       = core_value_reg[DATA_W-1];
    assign mag_comb  = neg ? (~core_value_reg + DATA_W'(1)) : core_value_reg;
    assign n_comb    = MOD_W'({map_index, 1'b1});
    assign flip_comb = neg && map_index[0];

    // Product of the held magnitude and the base factor, exact in 63 bits
    assign prod_full = PROD_W'(mag_reg) * PROD_W'(base_factor_reg);

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        map_bit_next  = map_bit_reg;
        in_range_next = in_range_reg;
        cmd.load      = 1'b0;
        cmd.a         = PROD_W'(mag_comb);
        cmd.m         = n_comb;
        cmd.flip      = flip_comb;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (idx_low)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_RUN1;
                    end
                    else
                    begin
                        // Out of range: answer next cycle, bit forced low
                        done_next     = 1'b1;
                        map_bit_next  = 1'b0;
                        in_range_next = 1'b0;
                    end
                end
            end
            ST_RUN1:
            begin
                if (stat.done)
                begin
                    if (stat.one || !parity_mode_reg)
                    begin
                        done_next     = 1'b1;
                        map_bit_next  = stat.one;
                        in_range_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        // Mixed mode: retest with r times the base factor
                        cmd.load   = 1'b1;
                        cmd.a      = prod_full;
                        cmd.m      = n_reg;
                        cmd.flip   = flip_reg;
                        state_next = ST_RUN2;
                    end
                end
            end
            ST_RUN2:
            begin
                if (stat.done)
                begin
                    done_next     = 1'b1;
                    map_bit_next  = stat.one;
                    in_range_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Payload: hold operands for the whole transaction
    always_ff @(posedge clk)
    begin
        map_bit_reg  <= map_bit_next;
        in_range_reg <= in_range_next;
        if (accept)
        begin
            n_reg    <= n_comb;
            mag_reg  <= mag_comb;
            flip_reg <= flip_comb;
        end
    end

    lrmb_jacobi u_jacobi (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign done     = done_reg;
    assign map_bit  = map_bit_reg;
    assign in_range = in_range_reg;

    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !idx_low) |=> (done && !in_range && !map_bit))
        else $error("out-of-range index not answered next cycle");

    a_mixed_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN2) |-> parity_mode_reg)
        else $error("second symbol run outside mixed mode");

    a_hit_first: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN1) && stat.done && stat.one)
            |=> (done && map_bit && in_range && !busy))
        else $error("first symbol hit not reported");

endmodule
